// ===== hdl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    // default number of slots in the chain
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int VAL_W = 32;
    localparam int PRI_W = 16;
    localparam int OCC_W = 5;

    // operation codes
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_TAKE_HEAD = 2'd1;
    localparam logic [1:0] OP_TAKE_TAIL = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]               func;
        logic signed [VAL_W-1:0]  entry_value;
        logic signed [PRI_W-1:0]  entry_priority;
    } in_t;

    // response payload
    typedef struct packed {
        logic signed [VAL_W-1:0]  removed_value;
        logic signed [PRI_W-1:0]  removed_priority;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } out_t;

    // one held entry
    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic signed [PRI_W-1:0]  prio;
    } slot_t;

    // per-cell move controls
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire                       clk,
    input  spq_pkg::cell_ctrl_t       ctrl,
    input  wire                       occupied,
    input  spq_pkg::slot_t            new_slot,
    input  spq_pkg::slot_t            left_slot,
    input  spq_pkg::slot_t            right_slot,
    output spq_pkg::slot_t            slot,
    output logic                      go
);

    spq_pkg::slot_t slot_reg;
    spq_pkg::slot_t slot_next;

    // the new entry goes before this one when it is empty or holds a larger priority
    assign go = !occupied || (slot_reg.prio > new_slot.prio);

    // next contents from the move controls
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.take_left)
        begin
            slot_next = left_slot;
        end
        else if (ctrl.load_new)
        begin
            slot_next = new_slot;
        end
        else if (ctrl.take_right)
        begin
            slot_next = right_slot;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
`default_nettype none

// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data  (spq_pkg::in_t)
// out       output     out_valid / out_ready   out_data (spq_pkg::out_t)
//
// all cells compare against the new priority of each request
// in parallel and shift left or right in the edge that accepts it
// one response register; a new request is taken while the previous response
// is being taken, so it sustains one request a cycle while out_ready is high
// reset clears the entry count and the response valid; slot contents are not reset
// a stalled output holds in_ready low until the response is taken

module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  spq_pkg::in_t     in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output spq_pkg::out_t    out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    spq_pkg::out_t          out_data_reg;
    spq_pkg::out_t          out_data_next;

    spq_pkg::slot_t         slots [DEPTH];
    logic [DEPTH-1:0]       go;
    spq_pkg::cell_ctrl_t    ctrl [DEPTH];
    spq_pkg::slot_t         new_slot;
    spq_pkg::slot_t         tail_slot;
    spq_pkg::slot_t         blank_slot;

    logic                   fire;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_insert;
    logic                   do_head;
    logic                   do_tail;
    logic [CW-1:0]          last_idx;

    // handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_insert = fire && (in_data.func == spq_pkg::OP_INSERT) && !is_full;
    assign do_head   = fire && (in_data.func == spq_pkg::OP_TAKE_HEAD) && !is_empty;
    assign do_tail   = fire && (in_data.func == spq_pkg::OP_TAKE_TAIL) && !is_empty;
    assign last_idx  = count_reg - CW'(1);

    assign new_slot.value = in_data.entry_value;
    assign new_slot.prio  = in_data.entry_priority;
    assign blank_slot     = '0;

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic go_left;

        if (g == 0)
        begin : g_head
            assign go_left = 1'b0;
        end
        else
        begin : g_body
            assign go_left = go[g-1];
        end

        assign ctrl[g].take_left  = do_insert && go_left;
        assign ctrl[g].load_new   = do_insert && go[g] && !go_left;
        assign ctrl[g].take_right = do_head;

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .occupied   (CW'(g) < count_reg),
            .new_slot   (new_slot),
            .left_slot  ((g == 0) ? blank_slot : slots[(g == 0) ? 0 : g - 1]),
            .right_slot ((g == DEPTH - 1) ? blank_slot
                                          : slots[(g == DEPTH - 1) ? g : g + 1]),
            .slot       (slots[g]),
            .go         (go[g])
        );
    end

    // one-hot selection of the last held entry
    always_comb
    begin
        tail_slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) == last_idx)
            begin
                tail_slot = tail_slot | slots[i];
            end
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_head || do_tail)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // response
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next                 = 1'b1;
            out_data_next                  = '0;
            out_data_next.status           = spq_pkg::ST_OK;
            out_data_next.occupancy        = spq_pkg::OCC_W'(count_next);
            case (in_data.func)
                spq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        out_data_next.status = spq_pkg::ST_OVER;
                    end
                end
                spq_pkg::OP_TAKE_HEAD:
                begin
                    if (is_empty)
                    begin
                        out_data_next.status = spq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        out_data_next.removed_value    = slots[0].value;
                        out_data_next.removed_priority = slots[0].prio;
                    end
                end
                spq_pkg::OP_TAKE_TAIL:
                begin
                    if (is_empty)
                    begin
                        out_data_next.status = spq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        out_data_next.removed_value    = tail_slot.value;
                        out_data_next.removed_priority = tail_slot.prio;
                    end
                end
                default:
                begin
                    out_data_next.status = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // count stays within the chain
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // an accepted insert into a non-full queue adds one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    // removal from empty reports underflow
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_empty && (in_data.func == spq_pkg::OP_TAKE_HEAD ||
                             in_data.func == spq_pkg::OP_TAKE_TAIL)
        |=> out_valid_reg && out_data_reg.status == spq_pkg::ST_UNDER)
        else $error("missing underflow status");

    // head and next entry stay in order
    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> slots[0].prio <= slots[1].prio)
        else $error("head entry out of order");

endmodule

`default_nettype wire

// ===== verif/spq_checker.sv =====
`default_nettype none

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    input  wire            in_ready,
    input  spq_pkg::in_t   in_data,
    input  wire            out_valid,
    input  wire            out_ready,
    input  spq_pkg::out_t  out_data,
    output int             fail_count,
    output int             awaited,
    output int             checked,
    output int             underflows,
    output int             overflows
);

    localparam int REPORT_LIMIT = 40;

    // shadow copy of the sorted slot chain
    logic signed [spq_pkg::VAL_W-1:0] shadow_value [DEPTH];
    logic signed [spq_pkg::PRI_W-1:0] shadow_priority [DEPTH];
    int                               shadow_count;

    // responses still owed by the block, oldest first
    spq_pkg::out_t awaited_responses [$];
    spq_pkg::out_t want;
    spq_pkg::out_t fresh;

    int errors = 0;
    int checked_n = 0;
    int under_n = 0;
    int over_n = 0;

    assign fail_count = errors;
    assign checked    = checked_n;
    assign underflows = under_n;
    assign overflows  = over_n;

    // apply one request to the shadow queue and return the response it causes
    function automatic spq_pkg::out_t serve_request(input spq_pkg::in_t req);
        spq_pkg::out_t                    resp;
        logic signed [spq_pkg::PRI_W-1:0] key;
        int                               pos;
        resp = '0;
        resp.status = spq_pkg::ST_OK;
        key = req.entry_priority;
        case (req.func)
            spq_pkg::OP_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    resp.status = spq_pkg::ST_OVER;
                else
                begin
                    // new entry goes after every entry with a key not above it
                    pos = 0;
                    while (pos < shadow_count && shadow_priority[pos] <= key)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_value[i]    = shadow_value[i-1];
                        shadow_priority[i] = shadow_priority[i-1];
                    end
                    shadow_value[pos]    = req.entry_value;
                    shadow_priority[pos] = key;
                    shadow_count++;
                end
            end
            spq_pkg::OP_TAKE_HEAD, spq_pkg::OP_TAKE_TAIL:
            begin
                if (shadow_count == 0)
                    resp.status = spq_pkg::ST_UNDER;
                else if (req.func == spq_pkg::OP_TAKE_HEAD)
                begin
                    resp.removed_value    = shadow_value[0];
                    resp.removed_priority = shadow_priority[0];
                    for (int i = 0; i + 1 < shadow_count; i++)
                    begin
                        shadow_value[i]    = shadow_value[i+1];
                        shadow_priority[i] = shadow_priority[i+1];
                    end
                    shadow_count--;
                end
                else
                begin
                    // a lone entry is both head and tail
                    resp.removed_value    = shadow_value[shadow_count-1];
                    resp.removed_priority = shadow_priority[shadow_count-1];
                    shadow_count--;
                end
            end
            default:
            begin
                // unused code leaves everything alone
            end
        endcase
        resp.occupancy = spq_pkg::OCC_W'(shadow_count);
        return resp;
    endfunction

    task automatic flag_field(input string field, input longint want_v, input longint got_v);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_responses.delete();
            shadow_count = 0;
            awaited <= 0;
        end
        else
        begin
            // response side first so a stray response cannot match this edge's request
            if (out_valid && out_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected response, expected none, got %p",
                                 $time, out_data);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    checked_n++;
                    if (out_data.removed_value !== want.removed_value)
                        flag_field("removed_value", want.removed_value,
                                   out_data.removed_value);
                    if (out_data.removed_priority !== want.removed_priority)
                        flag_field("removed_priority", want.removed_priority,
                                   out_data.removed_priority);
                    if (out_data.status !== want.status)
                        flag_field("status", want.status, out_data.status);
                    if (out_data.occupancy !== want.occupancy)
                        flag_field("occupancy", want.occupancy, out_data.occupancy);
                end
            end
            // accepted request
            if (in_valid && in_ready)
            begin
                fresh = serve_request(in_data);
                if (fresh.status == spq_pkg::ST_UNDER)
                    under_n++;
                if (fresh.status == spq_pkg::ST_OVER)
                    over_n++;
                awaited_responses.push_back(fresh);
            end
            awaited <= awaited_responses.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_sorted_priority_queue_core.sv =====
`default_nettype none

module tb_sorted_priority_queue_core;

    localparam int DEPTH         = spq_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 425;

    // func code the block must ignore
    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    spq_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_ready;
    spq_pkg::out_t  out_data;

    int    fail_count;
    int    awaited;
    int    checked;
    int    underflows;
    int    overflows;

    int    send_idle_pct;
    int    recv_stall_pct;
    int    cycle_count;
    int    requests_sent;
    bit    holding_valid;

    sorted_priority_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    spq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .awaited    (awaited),
        .checked    (checked),
        .underflows (underflows),
        .overflows  (overflows)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("sorted_priority_queue_core regression: fail");
        $finish;
    end

    // response side back-pressure
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // keys: a narrow band so ties are common, the full range, and extremes
    function automatic logic signed [spq_pkg::PRI_W-1:0] pick_priority();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return spq_pkg::PRI_W'(int'($urandom_range(8)) - 4);
        if (roll < 85)
            return spq_pkg::PRI_W'($urandom);
        case ($urandom_range(3))
            0: return {1'b1, {(spq_pkg::PRI_W-1){1'b0}}};
            1: return {1'b0, {(spq_pkg::PRI_W-1){1'b1}}};
            2: return {1'b1, {(spq_pkg::PRI_W-2){1'b0}}, 1'b1};
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [spq_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 80)
            return spq_pkg::VAL_W'($urandom);
        case ($urandom_range(3))
            0: return {1'b1, {(spq_pkg::VAL_W-1){1'b0}}};
            1: return {1'b0, {(spq_pkg::VAL_W-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // offer one request, hold it until taken, then idle at random
    task automatic send_request(input logic [1:0] func,
                                input logic signed [spq_pkg::VAL_W-1:0] v,
                                input logic signed [spq_pkg::PRI_W-1:0] p);
        spq_pkg::in_t req;
        int           idle;
        req.func           = func;
        req.entry_value    = v;
        req.entry_priority = p;
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct)
            idle++;
        holding_valid = (idle == 0);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // edge cases: empty removals, lone tail, extremes, ties, full queue
    task automatic directed_requests();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_request(spq_pkg::OP_TAKE_HEAD, '0, '0);
        send_request(spq_pkg::OP_TAKE_TAIL, '1, '1);
        send_request(OP_IGNORED, '1, '1);
        send_request(spq_pkg::OP_INSERT, 32'sd42, 16'sd7);
        send_request(spq_pkg::OP_TAKE_TAIL, '0, '0);
        // fill to the brim with extremes and a tie among the first entries
        send_request(spq_pkg::OP_INSERT, {1'b0, {(spq_pkg::VAL_W-1){1'b1}}},
                     {1'b0, {(spq_pkg::PRI_W-1){1'b1}}});
        send_request(spq_pkg::OP_INSERT, {1'b1, {(spq_pkg::VAL_W-1){1'b0}}},
                     {1'b1, {(spq_pkg::PRI_W-1){1'b0}}});
        send_request(spq_pkg::OP_INSERT, '0, '0);
        send_request(spq_pkg::OP_INSERT, '1, '1);
        send_request(spq_pkg::OP_INSERT, 32'sd1, 16'sd5);
        send_request(spq_pkg::OP_INSERT, 32'sd2, 16'sd5);
        for (int i = 0; i < DEPTH - 6; i++)
            send_request(spq_pkg::OP_INSERT, pick_value(), pick_priority());
        send_request(spq_pkg::OP_INSERT, 32'sd99, '0);
        send_request(spq_pkg::OP_TAKE_HEAD, '0, '0);
        send_request(spq_pkg::OP_TAKE_TAIL, '0, '0);
        send_request(OP_IGNORED, 32'h5A5A_A5A5, 16'h0F0F);
    endtask

    // random traffic that swings the fill level between empty and full
    task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
        int         done;
        int         bias;
        logic [1:0] op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        bias = 50;
        while (done < items)
        begin
            if (done % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: bias = 80;
                    1: bias = 20;
                    default: bias = 50;
                endcase
            end
            if ($urandom_range(99) < 3)
                send_request(OP_IGNORED, pick_value(), pick_priority());
            else
            begin
                if ($urandom_range(99) < bias)
                    op = spq_pkg::OP_INSERT;
                else if ($urandom_range(1) == 1)
                    op = spq_pkg::OP_TAKE_HEAD;
                else
                    op = spq_pkg::OP_TAKE_TAIL;
                // removals carry junk payload that must be ignored
                send_request(op, pick_value(), pick_priority());
                done++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        holding_valid  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 84, 0);
        run_phase(PHASE_ITEMS, 0, 84);
        run_phase(PHASE_ITEMS, 9, 9);
        if (holding_valid)
            in_valid <= 1'b0;

        // drain and give a stray response time to show up
        recv_stall_pct = 0;
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent across four back-pressure phases, %0d responses checked",
                 requests_sent, checked);
        $display("%0d underflows and %0d overflows exercised, %0d mismatches",
                 underflows, overflows, fail_count);
        if (fail_count == 0 && awaited == 0)
            $display("sorted_priority_queue_core regression: pass");
        else
            $display("sorted_priority_queue_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
verif/spq_checker.sv
verif/tb_sorted_priority_queue_core.sv
